/* src/u2rt_pkg.sv */
// Shared types and constants for the unsigned to radix text converter.
package u2rt_pkg;

  // Field and register widths
  localparam int VALUE_W  = 64;
  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int SYMBOL_W = 8;
  localparam int CFG_IDX_W = 2;

  // Divider: restoring steps done per cycle, and cycles per full division
  localparam int DIV_STEPS = 8;
  localparam int DIV_CYC   = VALUE_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd2;

  // Reset values of the registers
  localparam logic [RADIX_W-1:0] RADIX_RST      = 5'd16;
  localparam logic [VALUE_W-1:0] ALPHA_LOW_RST  = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] ALPHA_HIGH_RST = 64'h6665646362613938;

  // Symbol sent for a zero value
  localparam logic [SYMBOL_W-1:0] ZERO_CHAR = 8'h30;

  // Divider status toward the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
  } div_res_t;

endpackage

/* src/u2rt_div.sv */
// Divider: a digit of a 64-bit value, radix 2 to 16: shift, or restoring 8 bits a cycle.
module u2rt_div
  import u2rt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [RADIX_W-1:0] radix,
  output div_res_t           res,
  output logic [VALUE_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic [VALUE_W-1:0]   w_r, w_nxt, w_c;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt, rem_c;
  logic                 pow2;
  logic [2:0]           shamt;
  logic [RADIX_W-1:0]   radix_m1;

  // Power-of-two radix takes the fast path: mask and shift
  assign radix_m1 = radix - RADIX_W'(1);
  assign pow2     = (radix & radix_m1) == '0;

  always_comb begin
    case (radix)
      5'd2:    shamt = 3'd1;
      5'd4:    shamt = 3'd2;
      5'd8:    shamt = 3'd3;
      default: shamt = 3'd4;
    endcase
  end

  // Eight restoring steps: shift in the next dividend bit, subtract if it fits
  always_comb begin
    logic [DIGIT_W:0] t;
    logic             qb;
    w_c   = w_r;
    rem_c = rem_r;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {rem_c, w_c[VALUE_W-1]};
      qb = (t >= radix);
      if (qb) begin
        t = t - radix;
      end
      rem_c = t[DIGIT_W-1:0];
      w_c   = {w_c[VALUE_W-2:0], qb};
    end
  end

  // Next-state of control and working registers
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    w_nxt    = w_r;
    rem_nxt  = rem_r;
    if (start) begin
      if (pow2) begin
        w_nxt    = dividend >> shamt;
        rem_nxt  = dividend[DIGIT_W-1:0] & radix_m1[DIGIT_W-1:0];
        done_nxt = 1'b1;
      end else begin
        w_nxt    = dividend;
        rem_nxt  = '0;
        busy_nxt = 1'b1;
        step_nxt = '0;
      end
    end else if (busy_r) begin
      w_nxt    = w_c;
      rem_nxt  = rem_c;
      step_nxt = step_r + DIV_CNT_W'(1);
      if (step_r == DIV_CNT_W'(DIV_CYC - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done  = done_r;
  assign res.digit = rem_r;
  assign quotient  = w_r;

endmodule

/* src/unsigned_to_radix_text.sv */
// Top level: converts 64-bit unsigned values into radix text symbols.
//
// Input channel in_valid/in_ready/in_value takes one value per item. The
// result channel out_valid/out_ready/out_symbol/out_last sends one byte per
// digit, most significant digit first, out_last high on the final one. A
// zero value sends the single byte 0x30 whatever the alphabet holds.
// The cfg_we/cfg_index/cfg_wdata port writes radix (0), alphabet low (1)
// and alphabet high (2); write only while the block is idle.
//
// Digits come from a single divider, least significant first, into a
// 64-entry digit memory, and are then read back in reverse order.
// Radix 2, 4, 8 or 16 takes a digit by mask and shift; other radixes use
// 64-bit restoring division, 8 bits per cycle. Readback sends one symbol
// per cycle while the receiver is ready, through the registered memory
// read stage and the output register.
// A new value is taken once all reads of the previous one are issued.
// A stalled receiver holds the output register and halts readback; no
// symbol is lost. Reset restores radix 16 and the "0123456789abcdef"
// alphabet; the digit memory needs no clearing.
module unsigned_to_radix_text
  import u2rt_pkg::*;
#(
  parameter int MAX_DIGITS  = 64,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SYMBOL_W-1:0]  out_symbol,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_wdata
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_EMIT} state_t;

  // Configuration registers
  logic [RADIX_W-1:0] radix_r;
  logic [VALUE_W-1:0] alpha_lo_r;
  logic [VALUE_W-1:0] alpha_hi_r;
  logic [RADIX_W-1:0] eff_radix;

  // Sequencer
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_left_r, rd_left_nxt;
  logic          zero_r, zero_nxt;

  // Divider hookup
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  div_res_t           div_res;
  logic [VALUE_W-1:0] div_quo;
  logic               more;

  // Digit memory and readback pipeline
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [DIGIT_W-1:0] mem_q_r;
  logic               q_vld_r, q_vld_nxt;
  logic               q_last_r;
  logic               q_zero_r;
  logic               move_q;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [SYMBOL_W-1:0] out_symbol_r;
  logic                out_last_r;

  logic                in_acc;

  // Alphabet lookup: digit d is byte d of {high, low}
  function automatic logic [SYMBOL_W-1:0] symbol_of(
    input logic [DIGIT_W-1:0] d,
    input logic [VALUE_W-1:0] lo,
    input logic [VALUE_W-1:0] hi
  );
    logic [2*VALUE_W-1:0] alpha;
    alpha = {hi, lo};
    return alpha[d*SYMBOL_W +: SYMBOL_W];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RST;
      alpha_lo_r <= ALPHA_LOW_RST;
      alpha_hi_r <= ALPHA_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:      radix_r    <= cfg_wdata[RADIX_W-1:0];
        CFG_ALPHA_LOW:  alpha_lo_r <= cfg_wdata;
        CFG_ALPHA_HIGH: alpha_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Radix saturates to 2 .. MAX_SYMBOLS
  always_comb begin
    eff_radix = radix_r;
    if (radix_r < RADIX_W'(2)) begin
      eff_radix = RADIX_W'(2);
    end
    if (radix_r > RADIX_W'(MAX_SYMBOLS)) begin
      eff_radix = RADIX_W'(MAX_SYMBOLS);
    end
  end

  u2rt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (eff_radix),
    .res      (div_res),
    .quotient (div_quo)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Keep dividing while quotient is nonzero and the store has room
  assign more  = (div_quo != '0) && ((cnt_r + CW'(1)) < CW'(MAX_DIGITS));
  assign wr_en = (state_r == S_DIV) && div_res.done;

  assign div_start    = (in_acc && (in_value != '0)) || (wr_en && more);
  assign div_dividend = in_acc ? in_value : div_quo;

  // Readback: issue a read whenever the memory output stage will be free
  assign move_q  = q_vld_r && (!out_valid_r || out_ready);
  assign rd_en   = (state_r == S_EMIT) && (!q_vld_r || move_q);
  assign rd_addr = AW'(rd_left_r - CW'(1));

  // Sequencer next state
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    rd_left_nxt = rd_left_r;
    zero_nxt    = zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_value == '0) begin
            zero_nxt    = 1'b1;
            cnt_nxt     = CW'(1);
            rd_left_nxt = CW'(1);
            state_nxt   = S_EMIT;
          end else begin
            zero_nxt  = 1'b0;
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          cnt_nxt = cnt_r + CW'(1);
          if (!more) begin
            rd_left_nxt = cnt_r + CW'(1);
            state_nxt   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (rd_en) begin
          rd_left_nxt = rd_left_r - CW'(1);
          if (rd_left_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Readback stage and output register valids
  always_comb begin
    q_vld_nxt = q_vld_r;
    if (rd_en) begin
      q_vld_nxt = 1'b1;
    end else if (move_q) begin
      q_vld_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (move_q) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_left_r   <= '0;
      zero_r      <= 1'b0;
      q_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_left_r   <= rd_left_nxt;
      zero_r      <= zero_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Digit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[AW-1:0]] <= div_res.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r  <= mem[rd_addr];
      q_last_r <= (rd_left_r == CW'(1));
      q_zero_r <= zero_r;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (move_q) begin
      out_symbol_r <= q_zero_r ? ZERO_CHAR : symbol_of(mem_q_r, alpha_lo_r, alpha_hi_r);
      out_last_r   <= q_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;

endmodule
